// ===== rtl/core/declaration_lexer_macros.svh =====
// assertion helpers for the declaration lexer
`ifndef DECLARATION_LEXER_MACROS_SVH
`define DECLARATION_LEXER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define DL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("declaration lexer assertion failed");
// next-cycle implication
`define DL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("declaration lexer assertion failed");
`else
`define DL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/dl_pkg.sv =====
package dl_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 255;

  // result queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [39:0] WORD_ARRAY = 40'h6172726179;
  localparam logic [39:0] WORD_AS    = 40'h0000006173;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef enum logic [4:0] {
    KIND_NAME    = 5'd0,
    KIND_NUMBER  = 5'd1,
    KIND_ARRAY   = 5'd2,
    KIND_AS      = 5'd3,
    KIND_AMP     = 5'd4,
    KIND_STAR    = 5'd5,
    KIND_LBRK    = 5'd6,
    KIND_RBRK    = 5'd7,
    KIND_LPAR    = 5'd8,
    KIND_RPAR    = 5'd9,
    KIND_SEMI    = 5'd10,
    KIND_CARET   = 5'd11,
    KIND_NEWLINE = 5'd12,
    KIND_QUEST   = 5'd13,
    KIND_COMMA   = 5'd14,
    KIND_DCOLON  = 5'd15,
    KIND_BAD     = 5'd16
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NAME    = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_COLON   = 3'd4
  } mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [7:0]  length;
    logic        last;
  } result_t;

endpackage

// ===== rtl/core/declaration_lexer.sv =====
// declaration lexer: one text byte per cycle in, one token result per cycle out
//   (in while not full, out while not empty); results are registered in the queue
// throughput: one byte per cycle while each byte gives at most one result; bytes that
//   give two results are paced by the result side, one result transfer per cycle
// reset: synchronous active-low rst_n empties the result queue and returns to idle
module declaration_lexer #(
  parameter int MAX_TOKEN_LEN = dl_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_text,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  out_token_kind,
  output logic [31:0] out_start_position,
  output logic [7:0]  out_token_length,
  output logic        out_last_of_run
);

  logic            in_xfer;
  logic            out_xfer;
  logic [1:0]      res_cnt;
  dl_pkg::result_t res0, res1, head;

  // a byte transfers whenever the queue holds room for two results
  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  // front: mode register, position counter and token tracking
  dl_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_xfer),
    .char_code  (in_char_code),
    .end_of_text(in_end_of_text),
    .res_cnt    (res_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  // back: result queue, up to two writes and one read per cycle
  dl_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_cnt(res_cnt),
    .wr0   (res0),
    .wr1   (res1),
    .rd_en (out_xfer),
    .full  (full),
    .empty (empty),
    .head  (head)
  );

  // oldest waiting result drives the ports
  assign out_token_kind     = head.kind;
  assign out_start_position = head.start;
  assign out_token_length   = head.length;
  assign out_last_of_run    = head.last;

endmodule

// ===== rtl/core/dl_front.sv =====
module dl_front #(
  parameter int MAX_TOKEN_LEN = dl_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       char_code,
  input  logic             end_of_text,
  output logic [1:0]       res_cnt,
  output dl_pkg::result_t  res0,
  output dl_pkg::result_t  res1
);

  localparam int RunW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int CmpW = (RunW > 8) ? RunW : 8;

  dl_pkg::mode_t   mode_r, mode_nxt, mode_upd;
  logic [31:0]     pos_r, pos_nxt;
  logic [31:0]     begin_r, begin_nxt, begin_upd;
  logic [RunW-1:0] run_r, run_nxt, run_upd, run_base;
  logic [39:0]     prefix_r, prefix_nxt, prefix_upd, prefix_base;

  logic is_alpha, is_digit, cont, open_run, extend_en, starts;
  logic v0, v1, v2;
  dl_pkg::result_t r0, r1, r2;

  function automatic logic [7:0] sat_len(input logic [RunW-1:0] r);
    logic [CmpW-1:0] w;
    w = CmpW'(r);
    return (w > CmpW'(255)) ? 8'hFF : w[7:0];
  endfunction

  function automatic dl_pkg::kind_t name_kind(input logic [RunW-1:0] r,
                                              input logic [39:0] p);
    dl_pkg::kind_t k;
    k = dl_pkg::KIND_NAME;
    if (r == RunW'(5) && p == dl_pkg::WORD_ARRAY) k = dl_pkg::KIND_ARRAY;
    else if (r == RunW'(2) && p == dl_pkg::WORD_AS) k = dl_pkg::KIND_AS;
    return k;
  endfunction

  function automatic dl_pkg::kind_t punct_kind(input logic [7:0] c);
    dl_pkg::kind_t k;
    case (c)
      dl_pkg::CH_AMP:   k = dl_pkg::KIND_AMP;
      dl_pkg::CH_STAR:  k = dl_pkg::KIND_STAR;
      dl_pkg::CH_LBRK:  k = dl_pkg::KIND_LBRK;
      dl_pkg::CH_RBRK:  k = dl_pkg::KIND_RBRK;
      dl_pkg::CH_LPAR:  k = dl_pkg::KIND_LPAR;
      dl_pkg::CH_RPAR:  k = dl_pkg::KIND_RPAR;
      dl_pkg::CH_SEMI:  k = dl_pkg::KIND_SEMI;
      dl_pkg::CH_CARET: k = dl_pkg::KIND_CARET;
      dl_pkg::CH_NL:    k = dl_pkg::KIND_NEWLINE;
      dl_pkg::CH_QUEST: k = dl_pkg::KIND_QUEST;
      dl_pkg::CH_COMMA: k = dl_pkg::KIND_COMMA;
      default:          k = dl_pkg::KIND_BAD;
    endcase
    return k;
  endfunction

  // byte classes
  assign is_alpha = (char_code >= 8'h41 && char_code <= 8'h5A) ||
                    (char_code >= 8'h61 && char_code <= 8'h7A) ||
                    (char_code == dl_pkg::CH_UNDER);
  assign is_digit = (char_code >= 8'h30 && char_code <= 8'h39);

  // shared classification: continue open run, or start fresh
  always_comb begin
    case (mode_r)
      dl_pkg::MODE_NAME:    cont = is_alpha || is_digit;
      dl_pkg::MODE_NUMBER:  cont = is_digit;
      dl_pkg::MODE_COMMENT: cont = (char_code != dl_pkg::CH_NL);
      dl_pkg::MODE_COLON:   cont = (char_code == dl_pkg::CH_COLON);
      default:              cont = 1'b0;
    endcase
    open_run  = !cont && (is_alpha || is_digit);
    extend_en = open_run ||
                (cont && (mode_r == dl_pkg::MODE_NAME || mode_r == dl_pkg::MODE_NUMBER));
    starts    = open_run || (!cont && char_code == dl_pkg::CH_COLON);
    run_base    = open_run ? '0 : run_r;
    prefix_base = open_run ? '0 : prefix_r;
    run_upd    = run_r;
    prefix_upd = prefix_r;
    if (extend_en) begin
      run_upd = (run_base < RunW'(MAX_TOKEN_LEN)) ? run_base + RunW'(1) : run_base;
      prefix_upd = (run_base < RunW'(5)) ? {prefix_base[31:0], char_code} : prefix_base;
    end
    begin_upd = starts ? pos_r : begin_r;
    case (mode_r)
      dl_pkg::MODE_NAME, dl_pkg::MODE_NUMBER, dl_pkg::MODE_COMMENT:
        mode_upd = cont ? mode_r : dl_pkg::MODE_IDLE;
      default:
        mode_upd = dl_pkg::MODE_IDLE;
    endcase
    if (!cont) begin
      if (is_alpha)                            mode_upd = dl_pkg::MODE_NAME;
      else if (is_digit)                       mode_upd = dl_pkg::MODE_NUMBER;
      else if (char_code == dl_pkg::CH_HASH)   mode_upd = dl_pkg::MODE_COMMENT;
      else if (char_code == dl_pkg::CH_COLON)  mode_upd = dl_pkg::MODE_COLON;
    end
  end

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    begin_nxt  = begin_r;
    run_nxt    = run_r;
    prefix_nxt = prefix_r;
    if (in_valid) begin
      mode_nxt   = end_of_text ? dl_pkg::MODE_IDLE : mode_upd;
      pos_nxt    = end_of_text ? 32'd0 : pos_r + 32'd1;
      begin_nxt  = begin_upd;
      run_nxt    = run_upd;
      prefix_nxt = prefix_upd;
    end
  end

  // results
  always_comb begin
    r0 = '0;
    r1 = '0;
    r2 = '0;
    v0 = 1'b0;
    v2 = 1'b0;
    case (mode_r)
      dl_pkg::MODE_NAME: begin
        v0 = !cont;
        r0 = '{name_kind(run_r, prefix_r), begin_r, sat_len(run_r), 1'b0};
      end
      dl_pkg::MODE_NUMBER: begin
        v0 = !cont;
        r0 = '{dl_pkg::KIND_NUMBER, begin_r, sat_len(run_r), 1'b0};
      end
      dl_pkg::MODE_COLON: begin
        v0 = 1'b1;
        if (cont) r0 = '{dl_pkg::KIND_DCOLON, begin_r, 8'd2, 1'b0};
        else      r0 = '{dl_pkg::KIND_BAD, begin_r, 8'd1, 1'b0};
      end
      default: v0 = 1'b0;
    endcase
    v1 = !cont && !is_alpha && !is_digit && char_code != dl_pkg::CH_HASH &&
         char_code != dl_pkg::CH_SPACE && char_code != dl_pkg::CH_TAB &&
         char_code != dl_pkg::CH_COLON;
    r1 = '{punct_kind(char_code), pos_r, 8'd1, 1'b0};
    case (mode_upd)
      dl_pkg::MODE_NAME: begin
        v2 = end_of_text;
        r2 = '{name_kind(run_upd, prefix_upd), begin_upd, sat_len(run_upd), 1'b0};
      end
      dl_pkg::MODE_NUMBER: begin
        v2 = end_of_text;
        r2 = '{dl_pkg::KIND_NUMBER, begin_upd, sat_len(run_upd), 1'b0};
      end
      dl_pkg::MODE_COLON: begin
        v2 = end_of_text;
        r2 = '{dl_pkg::KIND_BAD, begin_upd, 8'd1, 1'b0};
      end
      default: v2 = 1'b0;
    endcase
    // pack in order, at most two valid
    if (v0) begin
      res0    = r0;
      res1    = v1 ? r1 : r2;
      res_cnt = (v1 || v2) ? 2'd2 : 2'd1;
    end else if (v1) begin
      res0    = r1;
      res1    = r2;
      res_cnt = v2 ? 2'd2 : 2'd1;
    end else begin
      res0    = r2;
      res1    = r2;
      res_cnt = v2 ? 2'd1 : 2'd0;
    end
    if (!in_valid) res_cnt = 2'd0;
    res0.last = (res_cnt == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= dl_pkg::MODE_IDLE;
      pos_r    <= '0;
      begin_r  <= '0;
      run_r    <= '0;
      prefix_r <= '0;
    end else begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      begin_r  <= begin_nxt;
      run_r    <= run_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

// ===== rtl/core/dl_queue.sv =====
`include "declaration_lexer_macros.svh"

module dl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      wr_cnt,
  input  dl_pkg::result_t wr0,
  input  dl_pkg::result_t wr1,
  input  logic            rd_en,
  output logic            full,
  output logic            empty,
  output dl_pkg::result_t head
);

  localparam int QAW = dl_pkg::QAW;
  localparam int QCW = dl_pkg::QCW;

  dl_pkg::result_t mem_r [dl_pkg::QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  // room for two writes is needed before the front may take a byte
  assign full  = cnt_r > QCW'(dl_pkg::QDEPTH - 2);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + QAW'(wr_cnt);
  assign rd_ptr_nxt = rd_ptr_r + QAW'(rd_en);
  assign cnt_nxt    = cnt_r + QCW'(wr_cnt) - QCW'(rd_en);

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) mem_r[wr_ptr_r] <= wr0;
    if (wr_cnt == 2'd2) mem_r[wr_ptr_r + QAW'(1)] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `DL_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= QCW'(dl_pkg::QDEPTH))
  `DL_ASSERT_IMP(a_no_overflow, clk, rst_n, wr_cnt != 2'd0, (cnt_r + QCW'(wr_cnt)) <= QCW'(dl_pkg::QDEPTH))
  `DL_ASSERT_IMP(a_no_underflow, clk, rst_n, rd_en, !empty)
  `DL_ASSERT_NXT(a_ptr_track, clk, rst_n, 1'b1, (wr_ptr_r - rd_ptr_r) == cnt_r[QAW-1:0])

endmodule
